[rtl/mexp_pkg.sv]
// Shared constants and types for the modular exponentiation block.
// The prime modulus, Barrett reduction constant and the controller/datapath structs.
// Depends on nothing.
package mexp_pkg;

  // Field widths
  localparam int unsigned MOD_W        = 30;
  localparam int unsigned EXP_IN_W     = 32;
  localparam int unsigned EXP_BITS_DEF = 32;

  // Prime modulus and Barrett constant floor(2^(2*MOD_W) / PRIME)
  localparam logic [MOD_W-1:0] PRIME      = 30'd998244353;
  localparam logic [MOD_W:0]   BARRETT_MU = 31'((64'd1 << (2 * MOD_W)) / 64'(PRIME));

  // Modulus multiples on the 32-bit remainder
  localparam logic [MOD_W+1:0] PRIME_X1 = {2'b00, PRIME};
  localparam logic [MOD_W+1:0] PRIME_X2 = {1'b0, PRIME, 1'b0};

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // take a new base and exponent
    logic start;    // launch one square-and-multiply round
    logic commit;   // write back the round's products
    logic capture;  // move the accumulator to the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic exp_zero;  // no exponent bits left
    logic mul_done;  // round products ready
  } dp_status_t;

endpackage

[rtl/mexp_if.sv]
// Valid/ready channel interfaces for the modular exponentiation block.
// Depends on mexp_pkg for the field widths.
interface mexp_in_if;
  logic                              valid;
  logic                              ready;
  logic [mexp_pkg::MOD_W-1:0]        base_value;
  logic [mexp_pkg::EXP_IN_W-1:0]     exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if;
  logic                              valid;
  logic                              ready;
  logic [mexp_pkg::MOD_W-1:0]        power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

[rtl/modular_exponentiation_prime.sv]
// Computes base_value ** exponent mod 998244353 by right-to-left square-and-multiply,
// one item at a time. Each round is an issue step plus the four-stage Barrett modular
// multiplier pair (product, quotient estimate, quotient times prime, final subtract).
// Only the low EXP_BITS exponent bits are used, and rounds run only up to the highest
// set exponent bit; a zero exponent runs no round and gives 1. The result becomes
// valid and the input is ready again in the same cycle. A finished result waits until
// the output register is free, so a stalled output delays it. A new item is taken
// while the previous result still waits on the output. Depends on mexp_pkg, mexp_if,
// mexp_mulmod, mexp_datapath and mexp_ctrl.
module modular_exponentiation_prime #(
  parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mexp_in_if.sink     in_s,
  mexp_out_if.source  out_s
);

  mexp_pkg::dp_cmd_t    dp_cmd;
  mexp_pkg::dp_status_t dp_status;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  mexp_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .base_value_i   (in_s.base_value),
    .exponent_i     (in_s.exponent),
    .power_result_o (out_s.power_result)
  );

endmodule

[rtl/mexp_mulmod.sv]
// Four-stage pipelined modular multiplier: a*b mod PRIME by Barrett reduction.
// Depends on mexp_pkg for the modulus and the Barrett constant.
module mexp_mulmod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mexp_pkg::MOD_W-1:0] a_i,
  input  logic [mexp_pkg::MOD_W-1:0] b_i,
  output logic                       done_o,
  output logic [mexp_pkg::MOD_W-1:0] result_o
);

  localparam int unsigned W  = mexp_pkg::MOD_W;
  localparam int unsigned RW = W + 2;  // remainder width, holds below 3*PRIME

  logic [3:0]        vld_q;
  logic [2*W-1:0]    prod_q;
  logic [2*W+1:0]    est_q;
  logic [RW-1:0]     xlo2_q, xlo3_q;
  logic [RW-1:0]     qp_q;
  logic [W-1:0]      res_q;

  logic [W:0]        q1;
  logic [W:0]        q3;
  logic [2*W:0]      qp_full;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     rem_red;

  // Track which stage holds live data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // Stage 1: full product
  always_ff @(posedge clk_i) begin
    prod_q <= (2*W)'(a_i) * (2*W)'(b_i);
  end

  // Stage 2: quotient estimate times Barrett constant
  assign q1 = prod_q[2*W-1:W-1];

  always_ff @(posedge clk_i) begin
    est_q  <= (2*W+2)'(q1) * (2*W+2)'(mexp_pkg::BARRETT_MU);
    xlo2_q <= prod_q[RW-1:0];
  end

  // Stage 3: quotient times modulus, low bits only
  assign q3      = est_q[2*W+1:W+1];
  assign qp_full = (2*W+1)'(q3) * (2*W+1)'(mexp_pkg::PRIME);

  always_ff @(posedge clk_i) begin
    qp_q   <= qp_full[RW-1:0];
    xlo3_q <= xlo2_q;
  end

  // Stage 4: remainder is below three moduli, subtract at most two
  assign rem = xlo3_q - qp_q;

  always_comb begin
    priority if (rem >= mexp_pkg::PRIME_X2) begin
      rem_red = rem - mexp_pkg::PRIME_X2;
    end else if (rem >= mexp_pkg::PRIME_X1) begin
      rem_red = rem - mexp_pkg::PRIME_X1;
    end else begin
      rem_red = rem;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= rem_red[W-1:0];
  end

  assign done_o   = vld_q[3];
  assign result_o = res_q;

endmodule

[rtl/mexp_datapath.sv]
// Datapath: base, accumulator and exponent registers, two modular multipliers
// and the output payload register. Depends on mexp_pkg and mexp_mulmod.
module mexp_datapath #(
  parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mexp_pkg::dp_cmd_t             cmd_i,
  output mexp_pkg::dp_status_t          status_o,
  input  logic [mexp_pkg::MOD_W-1:0]    base_value_i,
  input  logic [mexp_pkg::EXP_IN_W-1:0] exponent_i,
  output logic [mexp_pkg::MOD_W-1:0]    power_result_o
);

  localparam int unsigned W = mexp_pkg::MOD_W;

  logic [W-1:0]        base_q;
  logic [W-1:0]        acc_q;
  logic [EXP_BITS-1:0] exp_q;
  logic [W-1:0]        result_q;

  logic [EXP_BITS+mexp_pkg::EXP_IN_W-1:0] exp_ext;
  logic [W-1:0]        base_in_red;
  logic [W-1:0]        acc_prod;
  logic [W-1:0]        sq_prod;
  logic                acc_done;
  logic                sq_done;

  // Keep only the low EXP_BITS exponent bits, zero-extend when wider
  assign exp_ext = {EXP_BITS'(0), exponent_i};

  // Bring a base at or above the prime below it
  assign base_in_red = (base_value_i >= mexp_pkg::PRIME) ? base_value_i - mexp_pkg::PRIME
                                                          : base_value_i;

  // Load a new item or write back one round
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_in_red;
      acc_q  <= W'(1);
      exp_q  <= exp_ext[EXP_BITS-1:0];
    end else if (cmd_i.commit) begin
      base_q <= sq_prod;
      if (exp_q[0]) begin
        acc_q <= acc_prod;
      end
      exp_q <= exp_q >> 1;
    end
  end

  // Hold the finished result for the output side
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      result_q <= acc_q;
    end
  end

  mexp_mulmod u_acc_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .a_i      (acc_q),
    .b_i      (base_q),
    .done_o   (acc_done),
    .result_o (acc_prod)
  );

  mexp_mulmod u_sq_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .a_i      (base_q),
    .b_i      (base_q),
    .done_o   (sq_done),
    .result_o (sq_prod)
  );

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.mul_done = acc_done & sq_done;
  assign power_result_o    = result_q;

endmodule

[rtl/mexp_ctrl.sv]
// Controller: sequences load, square-and-multiply rounds and the output transfer.
// Depends on mexp_pkg for the command and status structs.
module mexp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mexp_pkg::dp_status_t status_i,
  output mexp_pkg::dp_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.exp_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on capture, drop after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[tb/sv/tb_modular_exponentiation_prime.sv]
// Self-checking testbench for modular_exponentiation_prime: drives base/exponent pairs
// and checks each power_result against an in-bench square-and-multiply predictor.
// Depends on mexp_pkg, mexp_if and the block's RTL.
module tb_modular_exponentiation_prime;

  localparam int unsigned      MOD_W       = mexp_pkg::MOD_W;
  localparam int unsigned      EXP_IN_W    = mexp_pkg::EXP_IN_W;
  localparam logic [MOD_W-1:0] PRIME       = mexp_pkg::PRIME;
  localparam int unsigned      EXP_BITS    = 32;
  localparam int unsigned      PRIME_MAX   = PRIME - 1;
  localparam int unsigned      DRAIN_WAIT  = 5 * EXP_BITS + 40;
  localparam int unsigned      LONG_HOLD   = 600;
  localparam int unsigned      PHASE_ITEMS = 270;

  logic clk;
  logic rst_n;

  mexp_in_if  in_ch ();
  mexp_out_if out_ch ();

  modular_exponentiation_prime #(
    .EXP_BITS(EXP_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  logic [MOD_W-1:0] expected_powers[$];
  int unsigned      send_idle_pct;
  int unsigned      sink_stall_pct;
  bit               sink_hold_pending;
  int unsigned      mismatch_count;
  int unsigned      operands_sent;
  int unsigned      powers_checked;
  int unsigned      zero_exp_sent;
  int unsigned      wide_base_sent;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #30_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Expected power: reduce the base, then one square-and-multiply round per exponent bit
  function automatic logic [MOD_W-1:0] predict_power(input logic [MOD_W-1:0] base_in,
                                                      input logic [EXP_IN_W-1:0] exp_in);
    logic [63:0] running;
    logic [63:0] acc;
    int unsigned bit_idx;
    running = 64'(base_in) % 64'(PRIME);
    acc     = 64'd1;
    for (bit_idx = 0; bit_idx < EXP_BITS; bit_idx++) begin
      if (bit_idx < EXP_IN_W && exp_in[bit_idx]) begin
        acc = (acc * running) % 64'(PRIME);
      end
      running = (running * running) % 64'(PRIME);
    end
    return acc[MOD_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [MOD_W-1:0] got,
                                 input logic [MOD_W-1:0] want);
    mismatch_count++;
    $display("[%0t] mismatch: %s: power_result got %0d, expected %0d", $realtime, what, got,
             want);
  endtask

  // Offer one item after a random idle gap, hold it until the transfer
  task automatic send_operands(input logic [MOD_W-1:0] base_in,
                               input logic [EXP_IN_W-1:0] exp_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.base_value <= base_in;
    in_ch.exponent   <= exp_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_powers = {expected_powers, predict_power(base_in, exp_in)};
    operands_sent++;
    if (exp_in == '0) zero_exp_sent++;
    if (base_in >= PRIME) wide_base_sent++;
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_powers.size() != 0) @(posedge clk);
  endtask

  // Corners: zero exponent, extreme bases and exponents, bases at or above the prime
  task automatic test_directed_corners();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_operands('0, '0);
    send_operands('1, '0);
    send_operands(PRIME, '0);
    send_operands('0, 32'd1);
    send_operands('0, '1);
    send_operands(30'd1, '1);
    send_operands(PRIME - 30'd1, '1);
    send_operands(PRIME - 30'd1, 32'd2);
    send_operands(PRIME, 32'd5);
    send_operands(PRIME + 30'd1, 32'd3);
    send_operands('1, '1);
    send_operands('1, 32'h8000_0000);
    send_operands(30'd2, 32'd29);
    send_operands(30'd3, 32'(PRIME) - 32'd1);
    send_operands(30'd12345, 32'(PRIME) - 32'd2);
    send_operands(30'h2AAA_AAAA, 32'h5555_5555);
    send_operands(30'h1555_5555, 32'hAAAA_AAAA);
    wait_drained();
  endtask

  task automatic send_random_item();
    logic [MOD_W-1:0]    base_rnd;
    logic [EXP_IN_W-1:0] exp_rnd;
    base_rnd = ($urandom_range(9) == 0) ? MOD_W'($urandom)
                                        : MOD_W'($urandom_range(PRIME_MAX));
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: exp_rnd = $urandom;
      6, 7, 8:          exp_rnd = $urandom >> $urandom_range(31);
      default:          exp_rnd = ($urandom_range(1) == 0) ? 32'd1 << $urandom_range(31) : '0;
    endcase
    send_operands(base_rnd, exp_rnd);
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned item_count);
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (item_count) send_random_item();
    wait_drained();
  endtask

  // Hold the output off for a long stretch while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct     = 0;
    sink_stall_pct    = 0;
    sink_hold_pending = 1'b1;
    repeat (10) send_operands(MOD_W'($urandom_range(PRIME_MAX)), 32'($urandom_range(15)));
    wait_drained();
  endtask

  // Drive ready: random stalls, plus a long counted hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_pending) begin
        sink_hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_powers.size() == 0) begin
        report_mismatch("result with nothing expected", out_ch.power_result, '0);
      end else begin
        if (out_ch.power_result !== expected_powers[0]) begin
          report_mismatch("wrong value", out_ch.power_result, expected_powers[0]);
        end
        void'(expected_powers.pop_front());
        powers_checked++;
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.base_value  = '0;
    in_ch.exponent    = '0;
    send_idle_pct     = 0;
    sink_stall_pct    = 0;
    sink_hold_pending = 1'b0;
    mismatch_count    = 0;
    operands_sent     = 0;
    powers_checked    = 0;
    zero_exp_sent     = 0;
    wide_base_sent    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_phase(0, 0, PHASE_ITEMS);
    test_random_phase(72, 0, PHASE_ITEMS);
    test_random_phase(0, 72, PHASE_ITEMS);
    test_random_phase(12, 12, PHASE_ITEMS);
    test_output_backpressure();

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d operand pairs (%0d zero exponents, %0d bases at or above the prime)",
             operands_sent, zero_exp_sent, wide_base_sent);
    $display("Checked %0d powers under four idle/stall mixes and one long output hold-off",
             powers_checked);
    if (mismatch_count == 0 && expected_powers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[modular_exponentiation_prime.f]
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_mulmod.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_prime.sv
tb/sv/tb_modular_exponentiation_prime.sv
